### rtl/sm4_pkg.sv
`timescale 1ns / 1ps
package sm4_pkg;

  localparam int unsigned Rounds = 32;

  typedef enum logic [2:0] {
    MODE_ECB = 3'd0,
    MODE_CBC = 3'd1,
    MODE_CFB = 3'd2,
    MODE_OFB = 3'd3,
    MODE_CTR = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_KEY_HIGH   = 3'd0,
    REG_KEY_LOW    = 3'd1,
    REG_IV_HIGH    = 3'd2,
    REG_IV_LOW     = 3'd3,
    REG_CHAIN_MODE = 3'd4,
    REG_DECRYPT    = 3'd5
  } reg_index_t;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

  function automatic logic [31:0] tau(input logic [31:0] x);
    tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] t_data(input logic [31:0] x);
    logic [31:0] b;
    b = tau(x);
    t_data = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
             ^ {b[7:0], b[31:8]};
  endfunction

  function automatic logic [31:0] t_key(input logic [31:0] x);
    logic [31:0] b;
    b = tau(x);
    t_key = b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
  endfunction

  function automatic logic [31:0] ck(input logic [4:0] i);
    logic [7:0] base;
    base = {1'b0, i, 2'b00};
    ck = {8'(base * 8'd7), 8'((base + 8'd1) * 8'd7), 8'((base + 8'd2) * 8'd7),
          8'((base + 8'd3) * 8'd7)};
  endfunction

endpackage

### rtl/sm4_round_core.sv
`timescale 1ns / 1ps
module sm4_round_core (
  input  logic         clk,
  input  logic         key_mode,
  input  logic         load,
  input  logic [127:0] load_value,
  input  logic         step,
  input  logic [31:0]  round_key,
  input  logic [4:0]   round_index,
  output logic [127:0] words,
  output logic [31:0]  new_word
);
  always_comb begin
    if (key_mode) begin
      new_word = words[127:96] ^ sm4_pkg::t_key(words[95:64] ^ words[63:32] ^ words[31:0]
                 ^ sm4_pkg::ck(round_index));
    end else begin
      new_word = words[127:96] ^ sm4_pkg::t_data(words[95:64] ^ words[63:32] ^ words[31:0]
                 ^ round_key);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      words <= load_value;
    end else if (step) begin
      words <= {words[95:0], new_word};
    end
  end
endmodule

### rtl/sm4_block_cipher_modes.sv
`timescale 1ns / 1ps
// Each block runs through S_PREP, S_LOAD, 32 rounds in S_RUN and S_OUT; when first_block
// starts a message, 32 key-expansion rounds in S_KEY come first. One round per cycle on a
// shared round unit; round keys live in a 32x32 synchronous RAM read one ahead.
// One block at a time: in_stall holds off a new block until the result is taken.
// Reset (rst, synchronous) clears control, registers, chain and counter.
module sm4_block_cipher_modes (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_high,
  input  logic [63:0] data_low,
  input  logic        first_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] result_high,
  output logic [63:0] result_low
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KEY   = 6'b000010,
    S_PREP  = 6'b000100,
    S_LOAD  = 6'b001000,
    S_RUN   = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t state;
  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic [2:0]  chain_mode;
  logic        decrypt;
  logic [63:0] chain_high, chain_low, counter_value;
  logic [63:0] din_high, din_low;
  logic [5:0]  round;
  logic [31:0] rk_mem [sm4_pkg::Rounds];
  logic [31:0] rk_rd;
  logic [4:0]  rd_addr;
  logic        core_key, core_load, core_step;
  logic [127:0] core_load_value, words;
  logic [31:0] new_word;
  logic [127:0] enc, cin;
  logic        dec_keys;

  sm4_round_core u_core (
    .clk(clk), .key_mode(core_key), .load(core_load), .load_value(core_load_value),
    .step(core_step), .round_key(rk_rd), .round_index(round[4:0]),
    .words(words), .new_word(new_word)
  );

  assign in_stall = (state != S_IDLE);
  assign dec_keys = decrypt && (chain_mode == sm4_pkg::MODE_CBC ||
                    !(chain_mode == sm4_pkg::MODE_CFB || chain_mode == sm4_pkg::MODE_OFB ||
                      chain_mode == sm4_pkg::MODE_CTR));
  assign core_key = (state == S_KEY);
  assign core_step = (state == S_KEY) || (state == S_RUN);
  assign enc = {words[31:0], words[63:32], words[95:64], words[127:96]};

  always_comb begin
    case (chain_mode)
      sm4_pkg::MODE_CBC: cin = decrypt ? {din_high, din_low}
                                       : {din_high ^ chain_high, din_low ^ chain_low};
      sm4_pkg::MODE_CFB, sm4_pkg::MODE_OFB: cin = {chain_high, chain_low};
      sm4_pkg::MODE_CTR: cin = {iv_high, counter_value};
      default: cin = {din_high, din_low};
    endcase
  end

  always_comb begin
    core_load = 1'b0;
    core_load_value = cin;
    if (state == S_IDLE && in_valid && first_block) begin
      core_load = 1'b1;
      core_load_value = {key_high ^ {sm4_pkg::FK[0], sm4_pkg::FK[1]},
                         key_low ^ {sm4_pkg::FK[2], sm4_pkg::FK[3]}};
    end else if (state == S_LOAD) begin
      core_load = 1'b1;
    end
  end

  // read address one round ahead of use
  always_comb begin
    logic [4:0] r;
    r = (state == S_LOAD) ? 5'd0 : 5'(round[4:0] + 5'd1);
    rd_addr = dec_keys ? 5'(5'd31 - r) : r;
  end

  always_ff @(posedge clk) begin
    if (state == S_KEY) begin
      rk_mem[round[4:0]] <= new_word;
    end
    rk_rd <= rk_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_high <= '0; key_low <= '0; iv_high <= '0; iv_low <= '0;
      chain_mode <= '0; decrypt <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        sm4_pkg::REG_KEY_HIGH:   key_high <= cfg_data;
        sm4_pkg::REG_KEY_LOW:    key_low <= cfg_data;
        sm4_pkg::REG_IV_HIGH:    iv_high <= cfg_data;
        sm4_pkg::REG_IV_LOW:     iv_low <= cfg_data;
        sm4_pkg::REG_CHAIN_MODE: chain_mode <= cfg_data[2:0];
        sm4_pkg::REG_DECRYPT:    decrypt <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      round <= '0;
      out_valid <= 1'b0;
      chain_high <= '0; chain_low <= '0; counter_value <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            din_high <= data_high;
            din_low <= data_low;
            round <= '0;
            if (first_block) begin
              chain_high <= iv_high;
              chain_low <= iv_low;
              counter_value <= '0;
              state <= S_KEY;
            end else begin
              state <= S_PREP;
            end
          end
        end
        S_KEY: begin
          round <= 6'(round + 6'd1);
          if (round == 6'(sm4_pkg::Rounds - 1)) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (chain_mode == sm4_pkg::MODE_CTR) begin
            counter_value <= 64'(counter_value + 64'd1);
          end
          state <= S_LOAD;
        end
        S_LOAD: begin
          round <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          round <= 6'(round + 6'd1);
          if (round == 6'(sm4_pkg::Rounds - 1)) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            case (chain_mode)
              sm4_pkg::MODE_CBC: begin
                if (decrypt) begin
                  {result_high, result_low} <= enc ^ {chain_high, chain_low};
                  {chain_high, chain_low} <= {din_high, din_low};
                end else begin
                  {result_high, result_low} <= enc;
                  {chain_high, chain_low} <= enc;
                end
              end
              sm4_pkg::MODE_CFB: begin
                {result_high, result_low} <= enc ^ {din_high, din_low};
                {chain_high, chain_low} <= decrypt ? {din_high, din_low}
                                                   : enc ^ {din_high, din_low};
              end
              sm4_pkg::MODE_OFB: begin
                {result_high, result_low} <= enc ^ {din_high, din_low};
                {chain_high, chain_low} <= enc;
              end
              sm4_pkg::MODE_CTR: {result_high, result_low} <= enc ^ {din_high, din_low};
              default: {result_high, result_low} <= enc;
            endcase
          end else if (!out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> in_stall) else $error("accept while busy");
  a_out_only_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result outside output state");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(result_high) && $stable(result_low)))
    else $error("stalled result changed");
endmodule
